// ===== hw/rtl/mbs_pkg.sv =====
// Package for the minimal block system finder.
// Payload structs, op and register codes, state enums and control structs.
// No dependencies.
package mbs_pkg;

  localparam int MAX_POINTS     = 64;
  localparam int MAX_GENERATORS = 8;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_BLOCK = 2'd1,
    OP_RUN   = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic [1:0] CFG_POINT_COUNT = 2'd0;
  localparam logic [1:0] CFG_GEN_COUNT   = 2'd1;

  localparam int IMG_W   = 6;
  localparam int LABEL_W = 6;

  typedef struct packed {
    op_t        op;
    logic [2:0] gen_index;
    logic [5:0] point;
    logic [5:0] image;
  } in_item_t;

  typedef struct packed {
    logic [5:0] out_point;
    logic [5:0] class_label;
    logic       last;
    logic       error;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic find_go;
    logic merge_go;
  } uf_req_t;

  typedef struct packed {
    logic done;
    logic merged;
  } uf_rsp_t;

  typedef enum logic [2:0] {
    U_IDLE,
    U_FRD,
    U_FCK,
    U_SRD,
    U_SR1,
    U_SR2
  } uf_state_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BRD,
    S_BEV,
    S_BMW,
    S_BCHK,
    S_QRD,
    S_QCAP,
    S_G1,
    S_G2,
    S_G3,
    S_G4,
    S_G5,
    S_L1,
    S_L2,
    S_L3
  } mbs_state_t;

endpackage

// ===== hw/rtl/mbs_perm_mem.sv =====
// Generator image table: one write port, one registered read port.
// Depends on mbs_pkg for the image width.
module mbs_perm_mem #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [mbs_pkg::IMG_W-1:0]  wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [mbs_pkg::IMG_W-1:0]  rdata
);

  logic [mbs_pkg::IMG_W-1:0] mem [DEPTH];
  logic [mbs_pkg::IMG_W-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_r <= mem[raddr];
    end
  end

  assign rdata = rd_r;

endmodule

// ===== hw/rtl/mbs_uf.sv =====
// Union-find unit: parent and class size stores with per-entry valid bits,
// a find walker and a union-by-size merge. Depends on mbs_pkg.
module mbs_uf #(
  parameter int NPTS = 64,
  parameter int PW   = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mbs_pkg::uf_req_t  req,
  input  logic [PW-1:0]     a,
  input  logic [PW-1:0]     b,
  output mbs_pkg::uf_rsp_t  rsp,
  output logic [PW-1:0]     root,
  output logic [PW-1:0]     absorbed
);

  localparam int SW = $clog2(NPTS + 1);

  mbs_pkg::uf_state_t st_r, st_nxt;

  logic [PW-1:0]   pmem [NPTS];
  logic [SW-1:0]   smem [NPTS];
  logic [NPTS-1:0] pvld_r;
  logic [NPTS-1:0] svld_r;
  logic [PW-1:0]   pdata_r;
  logic [SW-1:0]   sdata_r;
  logic [PW-1:0]   cur_r, r1_r, b_r, root_r, abs_r;
  logic [SW-1:0]   s1_r;
  logic            merge_r, second_r, done_r, merged_r;

  logic [PW-1:0]   lnk;
  logic [SW-1:0]   sval;
  logic [PW-1:0]   saddr;
  logic            swap;
  logic [PW-1:0]   win, lose;

  assign lnk   = pvld_r[cur_r] ? pdata_r : cur_r;
  assign saddr = (st_r == mbs_pkg::U_SR1) ? cur_r : r1_r;
  // class size of the entry read last cycle; untouched entries are singletons
  assign sval  = ((st_r == mbs_pkg::U_SR1) ? svld_r[r1_r] : svld_r[cur_r]) ?
                 sdata_r : SW'(1);
  assign swap  = s1_r < sval;
  assign win   = swap ? cur_r : r1_r;
  assign lose  = swap ? r1_r : cur_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      mbs_pkg::U_IDLE: begin
        if (req.find_go || req.merge_go) st_nxt = mbs_pkg::U_FRD;
      end
      mbs_pkg::U_FRD: st_nxt = mbs_pkg::U_FCK;
      mbs_pkg::U_FCK: begin
        if (lnk != cur_r) st_nxt = mbs_pkg::U_FRD;
        else if (!merge_r) st_nxt = mbs_pkg::U_IDLE;
        else if (!second_r) st_nxt = mbs_pkg::U_FRD;
        else if (r1_r == cur_r) st_nxt = mbs_pkg::U_IDLE;
        else st_nxt = mbs_pkg::U_SRD;
      end
      mbs_pkg::U_SRD: st_nxt = mbs_pkg::U_SR1;
      mbs_pkg::U_SR1: st_nxt = mbs_pkg::U_SR2;
      mbs_pkg::U_SR2: st_nxt = mbs_pkg::U_IDLE;
      default: st_nxt = mbs_pkg::U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    pdata_r <= pmem[cur_r];
    sdata_r <= smem[saddr];
    if (st_r == mbs_pkg::U_SR2) begin
      pmem[lose] <= win;
      smem[win]  <= s1_r + sval;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= mbs_pkg::U_IDLE;
      pvld_r   <= '0;
      svld_r   <= '0;
      done_r   <= 1'b0;
      merged_r <= 1'b0;
      merge_r  <= 1'b0;
      second_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= 1'b0;
      if (req.clear) begin
        pvld_r <= '0;
        svld_r <= '0;
      end
      unique case (st_r)
        mbs_pkg::U_IDLE: begin
          if (req.find_go || req.merge_go) begin
            cur_r    <= a;
            b_r      <= b;
            merge_r  <= req.merge_go;
            second_r <= 1'b0;
          end
        end
        mbs_pkg::U_FCK: begin
          if (lnk != cur_r) begin
            cur_r <= lnk;
          end else if (!merge_r) begin
            root_r   <= cur_r;
            done_r   <= 1'b1;
            merged_r <= 1'b0;
          end else if (!second_r) begin
            r1_r     <= cur_r;
            second_r <= 1'b1;
            cur_r    <= b_r;
          end else if (r1_r == cur_r) begin
            done_r   <= 1'b1;
            merged_r <= 1'b0;
          end
        end
        mbs_pkg::U_SR1: s1_r <= sval;
        mbs_pkg::U_SR2: begin
          pvld_r[lose] <= 1'b1;
          svld_r[win]  <= 1'b1;
          abs_r        <= lose;
          done_r       <= 1'b1;
          merged_r     <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign rsp.done   = done_r;
  assign rsp.merged = merged_r;
  assign root       = root_r;
  assign absorbed   = abs_r;

endmodule

// ===== hw/rtl/minimal_block_system_finder.sv =====
// Minimal block system finder, top level: command port, sequencer,
// point queue and label store. Depends on mbs_pkg, mbs_perm_mem, mbs_uf.
//
// Usage: write point_count (index 0) and generator_count (index 1) on the
// cfg_ port while idle. Commands go in on in_data with start, taken when
// busy is low. Op load writes one generator image, op block adds a point
// of the initial block; both keep busy low, give no result and may follow
// back to back. Op run raises busy from the next cycle,
// joins the block, drains the queue of merged points through the shared
// union-find unit, then emits one transfer per point on out_data, marked by
// out_valid for one cycle, last on the final point. A block of fewer than
// two distinct points gives a single transfer with error set. The receiver
// cannot stall; results are never held.
// Steps: a find walks the parent path from the point up to its root; a
// merge walks from both points and, when the roots differ, reads both class
// sizes and links the root of the smaller class under the other. A queued
// point is read and then takes one find and one merge per generator;
// labeling takes one find per point, plus a label read on a labeled root.
// Reset (rst_n low, synchronous) empties the block and restores
// point_count 64 and generator_count 1; generator images are not cleared.
module minimal_block_system_finder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  mbs_pkg::in_item_t  in_data,
  output logic               out_valid,
  output mbs_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [6:0]         cfg_wdata
);

  localparam int MAX_POINTS     = mbs_pkg::MAX_POINTS;
  localparam int MAX_GENERATORS = mbs_pkg::MAX_GENERATORS;
  localparam int PW  = $clog2(MAX_POINTS);
  localparam int NW  = $clog2(MAX_POINTS + 1);
  localparam int GNW = $clog2(MAX_GENERATORS + 1);
  localparam int AW  = $clog2(MAX_GENERATORS * MAX_POINTS);
  localparam int QW  = (PW > mbs_pkg::IMG_W) ? PW : mbs_pkg::IMG_W;

  mbs_pkg::mbs_state_t st_r, st_nxt;

  logic [6:0]     pc_r;
  logic [3:0]     gc_r;
  logic [NW-1:0]  n_eff;
  logic [GNW-1:0] ng_eff;

  logic [NW-1:0]  i_r, bcnt_r, head_r, tail_r, nl_r;
  logic [PW-1:0]  root_r, gamma_r, c1_r, froot_r;
  logic [1:0]     vcnt_r;
  logic [GNW-1:0] g_r;
  logic [MAX_POINTS-1:0] seen_r;

  logic [QW-1:0]  qmem [MAX_POINTS];
  logic [QW-1:0]  q_rd_r;
  logic [mbs_pkg::LABEL_W-1:0] lmem [MAX_POINTS];
  logic [mbs_pkg::LABEL_W-1:0] l_rd_r;

  logic               out_valid_r;
  mbs_pkg::out_item_t out_r;

  // datapath controls
  logic                perm_we, perm_re;
  logic [AW-1:0]       perm_waddr, perm_raddr;
  logic [mbs_pkg::IMG_W-1:0] perm_rd;
  logic                q_we, q_re;
  logic [PW-1:0]       q_waddr, q_raddr;
  logic [QW-1:0]       q_wdata;
  logic                l_we;
  mbs_pkg::uf_req_t    uf_req;
  mbs_pkg::uf_rsp_t    uf_rsp;
  logic [PW-1:0]       uf_a, uf_b, uf_root, uf_abs;

  logic          accept;
  logic [PW-1:0] img_base, img;
  logic          p_oob;
  logic          last_pt;

  assign accept = start && (st_r == mbs_pkg::S_IDLE);
  assign busy   = (st_r != mbs_pkg::S_IDLE);

  always_comb begin
    if (pc_r < 7'd2) n_eff = NW'(2);
    else if (int'(pc_r) > MAX_POINTS) n_eff = NW'(MAX_POINTS);
    else n_eff = NW'(pc_r);
    if (gc_r == 4'd0) ng_eff = GNW'(1);
    else if (int'(gc_r) > MAX_GENERATORS) ng_eff = GNW'(MAX_GENERATORS);
    else ng_eff = GNW'(gc_r);
  end

  // an image outside the active points leaves the point fixed
  assign img_base = (st_r == mbs_pkg::S_G4) ? froot_r : gamma_r;
  assign img      = (perm_rd < n_eff) ? PW'(perm_rd) : img_base;
  assign p_oob    = q_rd_r >= n_eff;
  assign last_pt  = (i_r == n_eff - NW'(1));

  mbs_perm_mem #(
    .DEPTH(MAX_GENERATORS * MAX_POINTS),
    .AW   (AW)
  ) u_perm (
    .clk  (clk),
    .we   (perm_we),
    .waddr(perm_waddr),
    .wdata(in_data.image),
    .re   (perm_re),
    .raddr(perm_raddr),
    .rdata(perm_rd)
  );

  mbs_uf #(
    .NPTS(MAX_POINTS),
    .PW  (PW)
  ) u_uf (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (uf_req),
    .a       (uf_a),
    .b       (uf_b),
    .rsp     (uf_rsp),
    .root    (uf_root),
    .absorbed(uf_abs)
  );

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      mbs_pkg::S_IDLE: begin
        if (accept && in_data.op == mbs_pkg::OP_RUN) st_nxt = mbs_pkg::S_BRD;
      end
      mbs_pkg::S_BRD: st_nxt = (i_r < bcnt_r) ? mbs_pkg::S_BEV : mbs_pkg::S_BCHK;
      mbs_pkg::S_BEV: begin
        if (p_oob || vcnt_r == 2'd0) st_nxt = mbs_pkg::S_BRD;
        else st_nxt = mbs_pkg::S_BMW;
      end
      mbs_pkg::S_BMW: if (uf_rsp.done) st_nxt = mbs_pkg::S_BRD;
      mbs_pkg::S_BCHK: st_nxt = (vcnt_r < 2'd2) ? mbs_pkg::S_IDLE : mbs_pkg::S_QRD;
      mbs_pkg::S_QRD: st_nxt = (head_r < tail_r) ? mbs_pkg::S_QCAP : mbs_pkg::S_L1;
      mbs_pkg::S_QCAP: st_nxt = mbs_pkg::S_G1;
      mbs_pkg::S_G1: st_nxt = mbs_pkg::S_G2;
      mbs_pkg::S_G2: if (uf_rsp.done) st_nxt = mbs_pkg::S_G3;
      mbs_pkg::S_G3: st_nxt = mbs_pkg::S_G4;
      mbs_pkg::S_G4: st_nxt = mbs_pkg::S_G5;
      mbs_pkg::S_G5: begin
        if (uf_rsp.done) begin
          st_nxt = (g_r + GNW'(1) == ng_eff) ? mbs_pkg::S_QRD : mbs_pkg::S_G1;
        end
      end
      mbs_pkg::S_L1: st_nxt = mbs_pkg::S_L2;
      mbs_pkg::S_L2: begin
        if (uf_rsp.done) begin
          if (seen_r[uf_root]) st_nxt = mbs_pkg::S_L3;
          else st_nxt = last_pt ? mbs_pkg::S_IDLE : mbs_pkg::S_L1;
        end
      end
      mbs_pkg::S_L3: st_nxt = last_pt ? mbs_pkg::S_IDLE : mbs_pkg::S_L1;
      default: st_nxt = mbs_pkg::S_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    perm_we    = accept && in_data.op == mbs_pkg::OP_LOAD &&
                 int'(in_data.gen_index) < MAX_GENERATORS &&
                 int'(in_data.point) < MAX_POINTS;
    perm_waddr = AW'(int'(in_data.gen_index) * MAX_POINTS + int'(in_data.point));
    perm_re    = 1'b0;
    perm_raddr = AW'(int'(g_r) * MAX_POINTS + int'(gamma_r));
    q_we       = 1'b0;
    q_waddr    = tail_r[PW-1:0];
    q_wdata    = QW'(uf_abs);
    q_re       = 1'b0;
    q_raddr    = i_r[PW-1:0];
    l_we       = 1'b0;
    uf_req     = '0;
    uf_a       = root_r;
    uf_b       = PW'(q_rd_r);
    unique case (st_r)
      mbs_pkg::S_IDLE: begin
        if (accept && in_data.op == mbs_pkg::OP_BLOCK &&
            int'(bcnt_r) < MAX_POINTS) begin
          q_we    = 1'b1;
          q_waddr = bcnt_r[PW-1:0];
          q_wdata = QW'(in_data.point);
        end
        uf_req.clear = accept && in_data.op == mbs_pkg::OP_RUN;
      end
      mbs_pkg::S_BRD: q_re = i_r < bcnt_r;
      mbs_pkg::S_BEV: uf_req.merge_go = !p_oob && vcnt_r != 2'd0;
      mbs_pkg::S_BMW: q_we = uf_rsp.done && uf_rsp.merged;
      mbs_pkg::S_QRD: begin
        q_re    = head_r < tail_r;
        q_raddr = head_r[PW-1:0];
      end
      mbs_pkg::S_G1: begin
        perm_re        = 1'b1;
        uf_req.find_go = 1'b1;
        uf_a           = gamma_r;
      end
      mbs_pkg::S_G3: begin
        perm_re    = 1'b1;
        perm_raddr = AW'(int'(g_r) * MAX_POINTS + int'(froot_r));
      end
      mbs_pkg::S_G4: begin
        uf_req.merge_go = 1'b1;
        uf_a            = c1_r;
        uf_b            = img;
      end
      mbs_pkg::S_G5: begin
        q_we = uf_rsp.done && uf_rsp.merged && int'(tail_r) < MAX_POINTS;
      end
      mbs_pkg::S_L1: begin
        uf_req.find_go = 1'b1;
        uf_a           = i_r[PW-1:0];
      end
      mbs_pkg::S_L2: l_we = uf_rsp.done && !seen_r[uf_root];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_we) qmem[q_waddr] <= q_wdata;
    if (q_re) q_rd_r <= qmem[q_raddr];
    if (l_we) lmem[uf_root] <= mbs_pkg::LABEL_W'(nl_r);
    l_rd_r <= lmem[uf_root];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= mbs_pkg::S_IDLE;
      pc_r        <= 7'd64;
      gc_r        <= 4'd1;
      bcnt_r      <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      vcnt_r      <= '0;
      out_valid_r <= 1'b0;
      seen_r      <= '0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == mbs_pkg::CFG_POINT_COUNT) pc_r <= cfg_wdata;
        else if (cfg_index == mbs_pkg::CFG_GEN_COUNT) gc_r <= cfg_wdata[3:0];
      end
      unique case (st_r)
        mbs_pkg::S_IDLE: begin
          if (q_we) bcnt_r <= bcnt_r + NW'(1);
          if (accept && in_data.op == mbs_pkg::OP_RUN) begin
            i_r    <= '0;
            vcnt_r <= '0;
            tail_r <= '0;
            root_r <= '0;
            seen_r <= '0;
          end
        end
        mbs_pkg::S_BEV: begin
          if (p_oob) begin
            i_r <= i_r + NW'(1);
          end else if (vcnt_r == 2'd0) begin
            root_r <= PW'(q_rd_r);
            vcnt_r <= 2'd1;
            i_r    <= i_r + NW'(1);
          end
        end
        mbs_pkg::S_BMW: begin
          if (uf_rsp.done) begin
            i_r <= i_r + NW'(1);
            if (uf_rsp.merged) begin
              tail_r <= tail_r + NW'(1);
              vcnt_r <= 2'd2;
            end
          end
        end
        mbs_pkg::S_BCHK: begin
          bcnt_r <= '0;
          head_r <= '0;
          if (vcnt_r < 2'd2) begin
            tail_r      <= '0;
            out_valid_r <= 1'b1;
            out_r       <= '{out_point: '0, class_label: '0, last: 1'b1, error: 1'b1};
          end
        end
        mbs_pkg::S_QRD: begin
          if (head_r >= tail_r) begin
            i_r  <= '0;
            nl_r <= '0;
          end
        end
        mbs_pkg::S_QCAP: begin
          gamma_r <= PW'(q_rd_r);
          head_r  <= head_r + NW'(1);
          g_r     <= '0;
        end
        mbs_pkg::S_G2: begin
          if (uf_rsp.done) begin
            c1_r    <= img;
            froot_r <= uf_root;
          end
        end
        mbs_pkg::S_G5: begin
          if (uf_rsp.done) begin
            g_r <= g_r + GNW'(1);
            if (q_we) tail_r <= tail_r + NW'(1);
          end
        end
        mbs_pkg::S_L2: begin
          if (uf_rsp.done && !seen_r[uf_root]) begin
            seen_r[uf_root] <= 1'b1;
            nl_r            <= nl_r + NW'(1);
            out_valid_r     <= 1'b1;
            out_r           <= '{out_point: 6'(i_r),
                                 class_label: mbs_pkg::LABEL_W'(nl_r),
                                 last: last_pt, error: 1'b0};
            i_r             <= i_r + NW'(1);
            if (last_pt) begin
              head_r <= '0;
              tail_r <= '0;
            end
          end
        end
        mbs_pkg::S_L3: begin
          out_valid_r <= 1'b1;
          out_r       <= '{out_point: 6'(i_r), class_label: l_rd_r,
                           last: last_pt, error: 1'b0};
          i_r         <= i_r + NW'(1);
          if (last_pt) begin
            head_r <= '0;
            tail_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
